### rtl/spl_pkg.sv
// Shared constants, request/status codes and control types of the sorted priority list.
package spl_pkg;

  // Fixed field widths of the request and result channels
  localparam int REQ_W     = 2;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // Default sizing
  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DROP_LOW = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the request and the per-cell compare flags
    logic apply;    // update the list and load the result register
  } spl_cmd_t;

endpackage

### rtl/spl_req_if.sv
// Request channel of the sorted priority list.
interface spl_req_if;
  import spl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [KEY_W-1:0] key;
  logic [PAY_W-1:0]        payload;

  modport source (output valid, req_type, key, payload, input ready);
  modport sink   (input valid, req_type, key, payload, output ready);
endinterface

### rtl/spl_rsp_if.sv
// Result channel of the sorted priority list.
interface spl_rsp_if;
  import spl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0]        out_payload;
  logic [COUNT_W-1:0]      count;

  modport source (output valid, status, out_key, out_payload, count, input ready);
  modport sink   (input valid, status, out_key, out_payload, count, output ready);
endinterface

### rtl/sorted_priority_list_core.sv
// Top level of the sorted priority list: controller and datapath.
//
// A bounded list of (key, payload) entries held in descending signed key order
// in a row of shifting cells. Each request on the req channel (insert, pop
// highest, remove lowest while two or more entries are held, clear) gives
// exactly one result on the rsp channel: a status code, the popped key and
// payload (zero unless a pop succeeded) and the entry count after the request.
// Both channels use valid/ready; a request moves at a clock edge where both
// are high.
// A request is handled in a capture step, where it is latched and all cells
// compare against the new key in parallel, followed by an apply step, where
// all cells shift at once and the result register is loaded; the apply step
// waits until the result register is free or being taken. A new request is
// taken only after the apply step of the last one.
// The result sits in an output register; while the receiver stalls, one
// further request is accepted and waits in its apply cycle until the
// result register is taken.
// Reset (rst, synchronous) empties the list and drops any pending result.
module sorted_priority_list_core #(
  parameter int CAPACITY     = spl_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = spl_pkg::PAYLOAD_BITS_DEF
) (
  input logic   clk,
  input logic   rst,
  spl_req_if.sink   req,
  spl_rsp_if.source rsp
);
  import spl_pkg::*;

  spl_cmd_t cmd;

  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  spl_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req.req_type),
    .key         (req.key),
    .payload     (req.payload),
    .status      (rsp.status),
    .out_key     (rsp.out_key),
    .out_payload (rsp.out_payload),
    .count       (rsp.count)
  );

endmodule

### rtl/spl_ctrl.sv
// Controller: request handshake, apply sequencing and result valid flag.
module spl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output spl_pkg::spl_cmd_t cmd
);
  import spl_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic state;
  logic state_next;
  logic out_full;
  logic out_full_next;
  logic apply;

  // Apply once the result register is free or is being emptied this cycle
  assign apply       = (state == S_APPLY) && (!out_full || rsp_ready);
  assign req_ready   = (state == S_IDLE);
  assign rsp_valid   = out_full;
  assign cmd.capture = req_valid && req_ready;
  assign cmd.apply   = apply;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_APPLY;
      S_APPLY: if (apply) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_full_next = out_full;
    if (apply) begin
      out_full_next = 1'b1;
    end else if (out_full && rsp_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

### rtl/spl_dp.sv
// Datapath: row of shifting sorted cells, entry count and result register.
module spl_dp #(
  parameter int CAPACITY     = spl_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = spl_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spl_pkg::spl_cmd_t                cmd,
  input  logic [spl_pkg::REQ_W-1:0]        req_type,
  input  logic signed [spl_pkg::KEY_W-1:0] key,
  input  logic [spl_pkg::PAY_W-1:0]        payload,
  output logic [spl_pkg::STATUS_W-1:0]     status,
  output logic signed [spl_pkg::KEY_W-1:0] out_key,
  output logic [spl_pkg::PAY_W-1:0]        out_payload,
  output logic [spl_pkg::COUNT_W-1:0]      count
);
  import spl_pkg::*;

  localparam int STORE_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  // Latched request
  logic [REQ_W-1:0]        req_q;
  logic signed [KEY_W-1:0] key_q;
  logic [STORE_W-1:0]      pay_q;
  logic [CAPACITY-1:0]     le_q;

  // Cell contents, head at index 0
  logic signed [KEY_W-1:0] keys [CAPACITY];
  logic [STORE_W-1:0]      pays [CAPACITY];

  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [STATUS_W-1:0]     status_next;
  logic                    full;
  logic                    empty;
  logic                    do_insert;
  logic                    do_pop;

  assign full      = (cnt == CNT_W'(CAPACITY));
  assign empty     = (cnt == '0);
  assign do_insert = cmd.apply && (req_q == REQ_INSERT) && !full;
  assign do_pop    = cmd.apply && (req_q == REQ_POP) && !empty;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      key_q <= key;
      pay_q <= payload[STORE_W-1:0];
    end
  end

  // Per-cell logic: compare at capture, shift at apply
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      // Flag cells whose key is at or below the new key, or that are empty
      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          le_q[i] <= (CNT_W'(i) >= cnt) || (keys[i] <= key);
        end
      end

      if (i == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (do_insert && le_q[0]) begin
            keys[0] <= key_q;
            pays[0] <= pay_q;
          end else if (do_pop) begin
            keys[0] <= keys[1];
            pays[0] <= pays[1];
          end
        end
      end else if (i == CAPACITY - 1) begin : g_tail
        always_ff @(posedge clk) begin
          if (do_insert && le_q[i]) begin
            if (le_q[i-1]) begin
              keys[i] <= keys[i-1];
              pays[i] <= pays[i-1];
            end else begin
              keys[i] <= key_q;
              pays[i] <= pay_q;
            end
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (do_insert && le_q[i]) begin
            if (le_q[i-1]) begin
              keys[i] <= keys[i-1];
              pays[i] <= pays[i-1];
            end else begin
              keys[i] <= key_q;
              pays[i] <= pay_q;
            end
          end else if (do_pop) begin
            keys[i] <= keys[i+1];
            pays[i] <= pays[i+1];
          end
        end
      end
    end
  endgenerate

  // Entry count and status
  always_comb begin
    cnt_next    = cnt;
    status_next = ST_OK;
    unique case (req_q)
      REQ_INSERT: begin
        if (full) status_next = ST_FULL;
        else      cnt_next = cnt + CNT_W'(1);
      end
      REQ_POP: begin
        if (empty) status_next = ST_EMPTY;
        else       cnt_next = cnt - CNT_W'(1);
      end
      REQ_DROP_LOW: begin
        if (cnt >= CNT_W'(2)) cnt_next = cnt - CNT_W'(1);
      end
      REQ_CLEAR: cnt_next = '0;
      default:   cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.apply) begin
      cnt <= cnt_next;
    end
  end

  assign cnt_ext = (CNT_W + COUNT_W)'(cnt_next);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status      <= status_next;
      count       <= cnt_ext[COUNT_W-1:0];
      out_key     <= do_pop ? keys[0] : '0;
      out_payload <= do_pop ? PAY_W'(pays[0]) : '0;
    end
  end

endmodule

### tb/sv/sorted_priority_list_core_tb.sv
// Self-checking testbench for the sorted priority list core: directed and random requests.
module sorted_priority_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spl_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 1400;

  typedef struct packed {
    logic [REQ_W-1:0]        kind;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [COUNT_W-1:0]      count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spl_req_if req_ch ();
  spl_rsp_if rsp_ch ();

  sorted_priority_list_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  int           accepted_count = 0;
  int           results_seen = 0;
  int           error_count = 0;
  int           rsp_hold_left = 0;

  // Shadow copy of the list, head (highest key) first
  logic signed [KEY_W-1:0] shadow_keys[CAPACITY];
  logic [PAY_W-1:0]        shadow_pays[CAPACITY];
  int                      shadow_len = 0;

  always #6 clk = ~clk;

  // Apply one request to the shadow list and return the result it should give
  function automatic list_result_t predict_request(list_req_t r);
    list_result_t            res;
    logic signed [KEY_W-1:0] new_key;
    int                      slot;
    res = '0;
    new_key = r.key;
    case (r.kind)
      REQ_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // newest goes ahead of the first entry with a key not above it
          slot = shadow_len;
          for (int i = 0; i < shadow_len; i++) begin
            if (shadow_keys[i] <= new_key) begin
              slot = i;
              break;
            end
          end
          for (int i = shadow_len; i > slot; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[slot] = new_key;
          shadow_pays[slot] = r.payload;
          shadow_len++;
        end
      end
      REQ_POP: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_key = shadow_keys[0];
          res.out_payload = shadow_pays[0];
          for (int i = 1; i < shadow_len; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_pays[i-1] = shadow_pays[i];
          end
          shadow_len--;
        end
      end
      REQ_DROP_LOW: begin
        if (shadow_len >= 2) shadow_len--;
      end
      REQ_CLEAR: begin
        shadow_len = 0;
      end
    endcase
    res.count = COUNT_W'(shadow_len);
    return res;
  endfunction

  function automatic void queue_request(logic [REQ_W-1:0] kind, logic signed [KEY_W-1:0] key,
                                        logic [PAY_W-1:0] payload);
    list_req_t r;
    r.kind = kind;
    r.key = key;
    r.payload = payload;
    pending_reqs.push_back(r);
  endfunction

  // Mix of a few close keys (to force ties), the extremes and full-range values
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 5))
      0: k = ($urandom_range(0, 4) - 2) <<< 16;
      1: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh8000_0000;
          1: k = 32'sh7fff_ffff;
          2: k = 32'sh8000_0001;
          default: k = 32'sh7fff_fffe;
        endcase
      end
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // Request driver: hold the offered request until taken, then predict it
  always @(posedge clk) begin : request_driver
    logic offer;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_INSERT;
      req_ch.key <= '0;
      req_ch.payload <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(predict_request(pending_reqs.pop_front()));
        accepted_count++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        offer = pending_reqs.size() != 0 &&
                !((accepted_count < 600 || accepted_count >= 850) &&
                  $urandom_range(0, 99) < 12);
        req_ch.valid <= offer;
        if (offer) begin
          req_ch.req_type <= pending_reqs[0].kind;
          req_ch.key <= pending_reqs[0].key;
          req_ch.payload <= pending_reqs[0].payload;
        end
      end
    end
  end

  // Result monitor: check each taken result and pace ready
  always @(posedge clk) begin : result_monitor
    list_result_t got;
    list_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.out_key = rsp_ch.out_key;
        got.out_payload = rsp_ch.out_payload;
        got.count = rsp_ch.count;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result status %0d key %0d payload %h count %0d",
                   $time, got.status, got.out_key, got.out_payload, got.count);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: mismatch: expected status %0d key %0d payload %h count %0d",
                     $time, want.status, want.out_key, want.out_payload, want.count);
            $display("%0t:           actual status %0d key %0d payload %h count %0d",
                     $time, got.status, got.out_key, got.out_payload, got.count);
          end
        end
        results_seen++;
        // one long hold-off so the block backs up and stalls its input
        if (results_seen == 250) rsp_hold_left = 80;
      end
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !((results_seen < 600 || results_seen >= 850) &&
                          $urandom_range(0, 99) < 12);
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin
    int n;
    int roll;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list cases, extreme keys and payloads, ties, each request
    queue_request(REQ_POP, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_request(REQ_DROP_LOW, '0, '0);
    queue_request(REQ_CLEAR, '0, '0);
    queue_request(REQ_INSERT, 32'sh0000_0000, 32'h0000_0000);
    queue_request(REQ_DROP_LOW, '0, '0);
    queue_request(REQ_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_request(REQ_INSERT, 32'sh8000_0000, 32'h1234_5678);
    queue_request(REQ_INSERT, 32'sh0000_0000, 32'ha5a5_a5a5);
    queue_request(REQ_INSERT, 32'sh0001_8000, 32'h0000_0001);
    queue_request(REQ_INSERT, 32'shffff_ffff, 32'h8000_0000);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_DROP_LOW, '0, '0);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_INSERT, 32'sh8000_0000, 32'h0000_00aa);
    queue_request(REQ_INSERT, 32'sh8000_0000, 32'h0000_00bb);
    queue_request(REQ_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_request(REQ_CLEAR, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_request(REQ_POP, '0, '0);
    queue_request(REQ_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_request(REQ_POP, 32'sh8000_0000, 32'h5555_5555);

    // pause the sender until the directed part has fully drained
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);

    // Random: fill-to-overflow runs, drains and mixed traffic
    burst = 0;
    while (pending_reqs.size() < RANDOM_REQUESTS) begin
      roll = $urandom_range(0, 9);
      if (burst % 6 == 0) begin
        queue_request(REQ_CLEAR, pick_key(), $urandom());
        n = $urandom_range(CAPACITY + 2, CAPACITY + 8);
        repeat (n) queue_request(REQ_INSERT, pick_key(), $urandom());
        repeat ($urandom_range(5, 20)) queue_request(REQ_POP, pick_key(), $urandom());
      end else if (roll < 3) begin
        // drain past empty, with some drop-lowest mixed in
        repeat ($urandom_range(10, 40)) begin
          if ($urandom_range(0, 99) < 80) queue_request(REQ_POP, pick_key(), $urandom());
          else queue_request(REQ_DROP_LOW, pick_key(), $urandom());
        end
      end else begin
        repeat ($urandom_range(20, 40)) begin
          n = $urandom_range(0, 99);
          if (n < 50) queue_request(REQ_INSERT, pick_key(), $urandom());
          else if (n < 80) queue_request(REQ_POP, pick_key(), $urandom());
          else if (n < 94) queue_request(REQ_DROP_LOW, pick_key(), $urandom());
          else queue_request(REQ_CLEAR, pick_key(), $urandom());
        end
      end
      burst++;
    end

    // drain until every result has been checked, then idle before the verdict
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
rtl/spl_pkg.sv
rtl/spl_req_if.sv
rtl/spl_rsp_if.sv
rtl/spl_ctrl.sv
rtl/spl_dp.sv
rtl/sorted_priority_list_core.sv
tb/sv/sorted_priority_list_core_tb.sv
